### rtl/ght_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ght_pkg
// Types and constants shared by the generational handle table and its parts.
// ============================================================================
package ght_pkg;

    localparam int GEN_W  = 16;
    localparam int SLOT_FIELD_W = 16;
    localparam int HANDLE_W = GEN_W + SLOT_FIELD_W;
    localparam int REFS_W = 16;
    localparam int KIND_W = 8;
    localparam int BYTES_W = 32;
    localparam int ADDR_W = 64;

    localparam logic [HANDLE_W-1:0] HANDLE_NONE = '1;
    localparam logic [REFS_W-1:0]   REFS_MAX    = '1;
    localparam logic [GEN_W-1:0]    GEN_RESET   = GEN_W'(1);

    typedef enum logic [2:0] {
        REQ_ALLOC   = 3'd0,
        REQ_FREE    = 3'd1,
        REQ_LOOKUP  = 3'd2,
        REQ_ADDREF  = 3'd3,
        REQ_RELEASE = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_BAD  = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [HANDLE_W-1:0] handle;
        logic [KIND_W-1:0]   res_type;
        logic [BYTES_W-1:0]  alloc_bytes;
        logic [ADDR_W-1:0]   backing_addr;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle_out;
        logic [ADDR_W-1:0]   address_out;
    } rsp_t;

    // One slot of the table as it lives in the slot memory.
    typedef struct packed {
        logic [GEN_W-1:0]   generation;
        logic [REFS_W-1:0]  refs;
        logic [KIND_W-1:0]  kind;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  address;
    } entry_t;

    // Result of the free-slot search.
    typedef struct packed {
        logic found;
    } search_flags_t;

endpackage

### rtl/ght_slot_finder.sv
`timescale 1ns / 1ps
// ============================================================================
// ght_slot_finder
// Rotating priority encoder: finds the first free slot at or after a start
// index, wrapping around to the lowest free slot.
// ============================================================================
module ght_slot_finder #(
    parameter int SLOT_COUNT = 256,
    parameter int SLOT_W     = 8
) (
    input  logic [SLOT_COUNT-1:0]  valid_bits,
    input  logic [SLOT_W-1:0]      start_idx,
    output ght_pkg::search_flags_t flags,
    output logic [SLOT_W-1:0]      free_idx
);
    import ght_pkg::*;

    logic              hit_upper;
    logic              hit_any;
    logic [SLOT_W-1:0] idx_upper;
    logic [SLOT_W-1:0] idx_any;

    // Scan from the top down so the lowest qualifying index wins.
    always_comb begin
        hit_upper = 1'b0;
        hit_any   = 1'b0;
        idx_upper = '0;
        idx_any   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!valid_bits[i]) begin
                hit_any = 1'b1;
                idx_any = SLOT_W'(i);
                if (SLOT_W'(i) >= start_idx) begin
                    hit_upper = 1'b1;
                    idx_upper = SLOT_W'(i);
                end
            end
        end
    end

    assign flags.found = hit_any;
    assign free_idx    = hit_upper ? idx_upper : idx_any;

endmodule

### rtl/generational_handle_table.sv
`timescale 1ns / 1ps
// ============================================================================
// generational_handle_table
// Slot table that issues and validates 32-bit generational handles.
// ============================================================================
// In the accept cycle the slot named by the handle is read from the slot
// memory into a register; in the execute state the entry is then checked,
// modified and written back while the response is loaded into the output
// register. No new request is accepted until the previous one has left the
// execute state, which waits only while the output register still holds a
// response that has not been taken. Because the write-back always lands
// before the next read is issued, no forwarding path is needed on the slot
// memory. Valid bits are kept in flip-flops and cleared at reset, so the
// table is usable immediately; other slot fields are defined only once a
// slot is allocated. Allocation picks the first free slot at or after a
// rotating start pointer, and each allocation stamps the slot with a 16-bit
// generation that then advances with wrap-around. While manager_enabled is
// low every request is answered with invalid-parameter status and nothing
// changes.
// ============================================================================
module generational_handle_table #(
    parameter int SLOT_COUNT = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration write channel: manager_enabled.
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data,
    // Request channel.
    input  logic          s_valid,
    output logic          s_ready,
    input  ght_pkg::req_t s_req,
    // Response channel.
    output logic          m_valid,
    input  logic          m_ready,
    output ght_pkg::rsp_t m_rsp
);
    import ght_pkg::*;

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_FIELD_W:0] SLOT_LIMIT = (SLOT_FIELD_W + 1)'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // Control and configuration registers.
    fsm_state_t              state_reg, state_next;
    logic                    enabled_reg;
    logic [SLOT_COUNT-1:0]   valid_reg;
    logic [SLOT_W-1:0]       search_reg, search_next;
    logic [GEN_W-1:0]        gen_reg, gen_next;
    logic                    m_valid_reg, m_valid_next;

    // Payload registers.
    req_t                    req_reg;
    entry_t                  entry_rd_reg;
    rsp_t                    rsp_reg;

    // The slot memory itself.
    entry_t                  slot_mem [SLOT_COUNT];

    logic                    s_accept;
    logic                    exec_fire;
    logic                    rsp_room;
    logic                    mem_we;
    logic [SLOT_W-1:0]       wr_idx;
    entry_t                  wr_entry;
    logic                    valid_set;
    logic                    valid_clr;
    logic                    alloc_commit;
    rsp_t                    rsp_new;

    search_flags_t           search_flags;
    logic [SLOT_W-1:0]       free_idx;

    logic [SLOT_W-1:0]       hdl_slot;
    logic                    hdl_in_range;
    logic                    hdl_live;
    logic                    hdl_ok;
    logic [REFS_W-1:0]       refs_dec;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;
    assign rsp_room  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_rsp     = rsp_reg;

    // ------------------------------------------------------------------
    // Free-slot search over the valid bits.
    // ------------------------------------------------------------------
    ght_slot_finder #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_finder (
        .valid_bits (valid_reg),
        .start_idx  (search_reg),
        .flags      (search_flags),
        .free_idx   (free_idx)
    );

    // ------------------------------------------------------------------
    // Sequencer: idle accepts a request, execute completes it.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        exec_fire  = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                // Hold the request until the output register can take it.
                if (rsp_room) begin
                    exec_fire  = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Slot memory: read on accept, write back from the execute cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[wr_idx] <= wr_entry;
        end
        if (s_accept) begin
            entry_rd_reg <= slot_mem[s_req.handle[SLOT_W-1:0]];
            req_reg      <= s_req;
        end
    end

    // ------------------------------------------------------------------
    // Handle check and the read-modify-write of one slot.
    // ------------------------------------------------------------------
    assign hdl_slot     = req_reg.handle[SLOT_W-1:0];
    assign hdl_in_range = {1'b0, req_reg.handle[SLOT_FIELD_W-1:0]} < SLOT_LIMIT;
    assign hdl_live     = hdl_in_range ? valid_reg[hdl_slot] : 1'b0;
    assign hdl_ok       = (req_reg.handle != HANDLE_NONE) && hdl_in_range && hdl_live
                          && (entry_rd_reg.generation == req_reg.handle[HANDLE_W-1:SLOT_FIELD_W]);
    assign refs_dec     = (entry_rd_reg.refs != '0) ? entry_rd_reg.refs - REFS_W'(1) : '0;

    always_comb begin
        mem_we       = 1'b0;
        wr_idx       = hdl_slot;
        wr_entry     = entry_rd_reg;
        valid_set    = 1'b0;
        valid_clr    = 1'b0;
        alloc_commit = 1'b0;
        search_next  = search_reg;
        gen_next     = gen_reg;
        rsp_new      = '0;
        rsp_new.status = STATUS_BAD;

        if (enabled_reg) begin
            case (req_reg.req_type)
                REQ_ALLOC: begin
                    if (req_reg.alloc_bytes != '0) begin
                        if (search_flags.found) begin
                            alloc_commit        = 1'b1;
                            mem_we              = 1'b1;
                            valid_set           = 1'b1;
                            wr_idx              = free_idx;
                            wr_entry.generation = gen_reg;
                            wr_entry.refs       = REFS_W'(1);
                            wr_entry.kind       = req_reg.res_type;
                            wr_entry.bytes      = req_reg.alloc_bytes;
                            wr_entry.address    = req_reg.backing_addr;
                            search_next = (free_idx == LAST_SLOT) ? '0
                                                                  : free_idx + SLOT_W'(1);
                            gen_next    = gen_reg + GEN_W'(1);
                            rsp_new.status      = STATUS_OK;
                            rsp_new.handle_out  = {gen_reg, SLOT_FIELD_W'(free_idx)};
                            rsp_new.address_out = req_reg.backing_addr;
                        end else begin
                            rsp_new.status = STATUS_FULL;
                        end
                    end
                end
                REQ_FREE: begin
                    if (hdl_ok) begin
                        rsp_new.status = STATUS_OK;
                        valid_clr      = 1'b1;
                    end
                end
                REQ_LOOKUP: begin
                    if (hdl_ok) begin
                        rsp_new.status      = STATUS_OK;
                        rsp_new.address_out = entry_rd_reg.address;
                    end
                end
                REQ_ADDREF: begin
                    if (hdl_ok) begin
                        rsp_new.status = STATUS_OK;
                        mem_we         = 1'b1;
                        if (entry_rd_reg.refs != REFS_MAX) begin
                            wr_entry.refs = entry_rd_reg.refs + REFS_W'(1);
                        end
                    end
                end
                REQ_RELEASE: begin
                    if (hdl_ok) begin
                        rsp_new.status = STATUS_OK;
                        mem_we         = 1'b1;
                        wr_entry.refs  = refs_dec;
                        if (refs_dec == '0) begin
                            valid_clr = 1'b1;
                        end
                    end
                end
                default: begin
                    rsp_new.status = STATUS_BAD;
                end
            endcase
        end

        // Nothing commits outside the execute cycle.
        if (!exec_fire) begin
            mem_we       = 1'b0;
            valid_set    = 1'b0;
            valid_clr    = 1'b0;
            alloc_commit = 1'b0;
            search_next  = search_reg;
            gen_next     = gen_reg;
        end
    end

    // ------------------------------------------------------------------
    // Table control state and configuration.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            valid_reg   <= '0;
            search_reg  <= '0;
            gen_reg     <= GEN_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                enabled_reg <= cfg_data;
            end
            if (valid_set) begin
                valid_reg[wr_idx] <= 1'b1;
            end else if (valid_clr) begin
                valid_reg[wr_idx] <= 1'b0;
            end
            search_reg <= search_next;
            gen_reg    <= gen_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            rsp_reg <= rsp_new;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == FSM_EXEC)
        else $error("accepted request did not move to execute");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |-> (!m_valid_reg || m_ready))
        else $error("response overwritten before it was taken");

    a_alloc_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_commit |=> valid_reg[$past(wr_idx)])
        else $error("allocated slot not marked valid");

    a_gen_only_on_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen_reg != $past(gen_reg)) |-> $past(alloc_commit))
        else $error("generation advanced without an allocation");

    a_write_only_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == FSM_EXEC) && !s_ready)
        else $error("slot memory written outside the execute cycle");

endmodule
